>>> rtl/core/wildcard_pattern_matcher_defines.svh
// Assertion helpers shared by the matcher's modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// The condition must never be true at a clock edge.
`define WPM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wildcard matcher: forbidden condition seen");

// The antecedent implies the consequent at the same edge.
`define WPM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wildcard matcher: implication violated");

`endif

>>> rtl/core/wpm_pkg.sv
package wpm_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_STAR = 1'b0;
  localparam logic REG_ANY  = 1'b1;

  // Register reset values.
  localparam logic [7:0] STAR_RESET = 8'h2a;
  localparam logic [7:0] ANY_RESET  = 8'h3f;

  // Kinds of input bytes.
  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_PATTERN = 1'b1;

  // Cursor operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_TAKE_STAR,
    OP_ADVANCE,
    OP_BACKTRACK,
    OP_SKIP_STAR,
    OP_FINISH
  } wpm_op_t;

  typedef struct packed {
    logic    load;
    wpm_op_t op;
  } wpm_cmd_t;

  typedef struct packed {
    logic text_more;
    logic pat_more;
    logic star_hit;
    logic char_hit;
    logic star_seen;
  } wpm_status_t;

endpackage

>>> rtl/core/wpm_ram.sv
module wpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/wpm_datapath.sv
`include "wildcard_pattern_matcher_defines.svh"

module wpm_datapath
  import wpm_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_kind,
  input  logic [7:0]  in_char_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  input  wpm_cmd_t    cmd,
  output wpm_status_t status
);

  localparam int AW = $clog2(MAX_LEN);
  localparam logic [AW-1:0] FILL_LIMIT = AW'(MAX_LEN - 1);

  logic [7:0]    star_code_r, any_code_r;
  logic [AW-1:0] text_fill_r, text_fill_nxt;
  logic [AW-1:0] pattern_fill_r, pattern_fill_nxt;
  logic [AW-1:0] text_pos_r, text_pos_nxt;
  logic [AW-1:0] pattern_pos_r, pattern_pos_nxt;
  logic [AW-1:0] after_star_pos_r, after_star_pos_nxt;
  logic [AW-1:0] star_text_pos_r, star_text_pos_nxt;
  logic          star_seen_r, star_seen_nxt;
  logic          text_closed_r, text_closed_nxt;
  logic          text_we, pattern_we;
  logic [7:0]    text_rd, pattern_rd;
  logic          cfg_write;

  // Configuration registers; the low address bits are not decoded.
  assign cfg_write = psel & penable & pwrite;
  assign prdata    = {24'd0, (paddr[2] == REG_ANY) ? any_code_r : star_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      star_code_r <= STAR_RESET;
      any_code_r  <= ANY_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_STAR) begin
        star_code_r <= pwdata[7:0];
      end else begin
        any_code_r <= pwdata[7:0];
      end
    end
  end

  // Store writes while loading; a full store drops further bytes.
  assign text_we = cmd.load & (in_kind == KIND_TEXT) & (in_char_byte != 8'd0) &
                   ~text_closed_r & (text_fill_r < FILL_LIMIT);
  assign pattern_we = cmd.load & (in_kind == KIND_PATTERN) & (in_char_byte != 8'd0) &
                      (pattern_fill_r < FILL_LIMIT);

  wpm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_fill_r),
    .wdata (in_char_byte),
    .raddr (text_pos_r),
    .rdata (text_rd)
  );

  wpm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pattern_ram (
    .clk   (clk),
    .we    (pattern_we),
    .waddr (pattern_fill_r),
    .wdata (in_char_byte),
    .raddr (pattern_pos_r),
    .rdata (pattern_rd)
  );

  // Status for the controller; read data belongs to the current cursors.
  assign status.text_more = text_pos_r < text_fill_r;
  assign status.pat_more  = pattern_pos_r < pattern_fill_r;
  assign status.star_hit  = status.pat_more & (pattern_rd == star_code_r);
  assign status.char_hit  = status.pat_more &
                            ((pattern_rd == any_code_r) | (pattern_rd == text_rd));
  assign status.star_seen = star_seen_r;

  // Fill counts and cursor updates.
  always_comb begin
    text_fill_nxt      = text_fill_r;
    pattern_fill_nxt   = pattern_fill_r;
    text_closed_nxt    = text_closed_r;
    text_pos_nxt       = text_pos_r;
    pattern_pos_nxt    = pattern_pos_r;
    after_star_pos_nxt = after_star_pos_r;
    star_text_pos_nxt  = star_text_pos_r;
    star_seen_nxt      = star_seen_r;

    if (cmd.load && (in_kind == KIND_TEXT) && (in_char_byte == 8'd0)) begin
      text_closed_nxt = 1'b1;
    end
    if (text_we) begin
      text_fill_nxt = text_fill_r + AW'(1);
    end
    if (pattern_we) begin
      pattern_fill_nxt = pattern_fill_r + AW'(1);
    end

    unique case (cmd.op)
      OP_START: begin
        text_pos_nxt       = '0;
        pattern_pos_nxt    = '0;
        after_star_pos_nxt = '0;
        star_text_pos_nxt  = '0;
        star_seen_nxt      = 1'b0;
      end
      OP_TAKE_STAR: begin
        pattern_pos_nxt    = pattern_pos_r + AW'(1);
        after_star_pos_nxt = pattern_pos_r + AW'(1);
        star_text_pos_nxt  = text_pos_r;
        star_seen_nxt      = 1'b1;
      end
      OP_ADVANCE: begin
        pattern_pos_nxt = pattern_pos_r + AW'(1);
        text_pos_nxt    = text_pos_r + AW'(1);
      end
      OP_BACKTRACK: begin
        star_text_pos_nxt = star_text_pos_r + AW'(1);
        text_pos_nxt      = star_text_pos_r + AW'(1);
        pattern_pos_nxt   = after_star_pos_r;
      end
      OP_SKIP_STAR: begin
        pattern_pos_nxt = pattern_pos_r + AW'(1);
      end
      OP_FINISH: begin
        text_fill_nxt    = '0;
        pattern_fill_nxt = '0;
        text_closed_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_fill_r      <= '0;
      pattern_fill_r   <= '0;
      text_closed_r    <= 1'b0;
      text_pos_r       <= '0;
      pattern_pos_r    <= '0;
      after_star_pos_r <= '0;
      star_text_pos_r  <= '0;
      star_seen_r      <= 1'b0;
    end else begin
      text_fill_r      <= text_fill_nxt;
      pattern_fill_r   <= pattern_fill_nxt;
      text_closed_r    <= text_closed_nxt;
      text_pos_r       <= text_pos_nxt;
      pattern_pos_r    <= pattern_pos_nxt;
      after_star_pos_r <= after_star_pos_nxt;
      star_text_pos_r  <= star_text_pos_nxt;
      star_seen_r      <= star_seen_nxt;
    end
  end

  // The retry point never runs ahead of the text cursor.
  `WPM_ASSERT_NEVER(a_star_behind_text, star_seen_r && (star_text_pos_r > text_pos_r))
  // Loading and cursor operations never coincide.
  `WPM_ASSERT_NEVER(a_load_vs_op, cmd.load && (cmd.op != OP_NONE))

endmodule

>>> rtl/core/wpm_ctrl.sv
`include "wildcard_pattern_matcher_defines.svh"

module wpm_ctrl
  import wpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  input  wpm_status_t status,
  output wpm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_READ,
    S_EVAL,
    S_TAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_matched_r, out_matched_nxt;
  logic   in_term, in_accept;

  // A pattern end byte waits while an earlier verdict is still held.
  assign in_term   = (in_kind == KIND_PATTERN) && (in_char_byte == 8'd0);
  assign in_stall  = (state_r != S_LOAD) || (out_valid_r && in_term);
  assign in_accept = in_valid && !in_stall;

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // Next state, commands and verdict.
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    cmd.load        = 1'b0;
    cmd.op          = OP_NONE;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_accept && in_term) begin
          cmd.op    = OP_START;
          state_nxt = S_READ;
        end else if (in_accept) begin
          cmd.load = 1'b1;
        end
      end
      S_READ: begin
        state_nxt = status.text_more ? S_EVAL : S_TAIL;
      end
      S_EVAL: begin
        state_nxt = S_READ;
        priority if (status.star_hit) begin
          cmd.op = OP_TAKE_STAR;
        end else if (status.char_hit) begin
          cmd.op = OP_ADVANCE;
        end else if (status.star_seen) begin
          cmd.op = OP_BACKTRACK;
        end else begin
          cmd.op          = OP_FINISH;
          out_valid_nxt   = 1'b1;
          out_matched_nxt = 1'b0;
          state_nxt       = S_LOAD;
        end
      end
      S_TAIL: begin
        if (status.star_hit) begin
          cmd.op    = OP_SKIP_STAR;
          state_nxt = S_READ;
        end else begin
          cmd.op          = OP_FINISH;
          out_valid_nxt   = 1'b1;
          out_matched_nxt = !status.pat_more;
          state_nxt       = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      out_valid_r   <= 1'b0;
      out_matched_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      out_matched_r <= out_matched_nxt;
    end
  end

  // No byte is taken while a match is running.
  `WPM_ASSERT_NEVER(a_no_accept_busy, (state_r != S_LOAD) && in_valid && !in_stall)
  // A verdict only appears at the end of a match.
  `WPM_ASSERT_IMPLY(a_verdict_source, $rose(out_valid_r),
                    $past(state_r == S_EVAL) || $past(state_r == S_TAIL))
  // A match never starts while a verdict is still held.
  `WPM_ASSERT_NEVER(a_start_free, (cmd.op == OP_START) && out_valid_r)

endmodule

>>> rtl/core/wildcard_pattern_matcher.sv
// Loading: one byte per cycle while no match runs (a pattern end byte also waits for a held
// verdict); text and pattern bytes are taken back to back. Matching: the pattern end byte
// starts the match; each matcher step is a read of both stores through their registered read
// ports, then evaluation. The verdict is registered from the last step; steps grow with
// text and pattern length and with backtracking. Reset (rst_n low, synchronous) clears fills,
// cursors, verdict and codes (star 0x2a, any 0x3f); store contents stay undefined and are never read.
module wildcard_pattern_matcher
  import wpm_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wpm_cmd_t    cmd;
  wpm_status_t status;

  assign pready = 1'b1;

  wpm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched),
    .status       (status),
    .cmd          (cmd)
  );

  wpm_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wpm_pkg::*;

  localparam int MAX_LEN = 256;

  // One input beat as queued for the driver; drain holds it back until all verdicts are in.
  typedef struct packed {
    logic       drain;
    logic       kind;
    logic [7:0] chr;
  } beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_TEXT;
  logic [7:0]  in_char_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_matched;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'b000;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  wildcard_pattern_matcher #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Predicted matcher state: stored strings, their fills and the active codes.
  logic [7:0] text_chars [MAX_LEN];
  logic [7:0] pat_chars [MAX_LEN];
  int         text_len = 0;
  int         pat_len = 0;
  bit         text_done = 1'b0;
  logic [7:0] star_cur = STAR_RESET;
  logic [7:0] any_cur = ANY_RESET;

  beat_t beat_q[$];
  logic  verdict_q[$];
  int    beat_total = 0;
  int    err_count = 0;
  bit    send_quiet = 1'b0;
  bit    recv_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic int send_pause();
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    return send_quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic int recv_pause();
    if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
    return recv_quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Greedy glob match with a single backtrack point at the latest star.
  function automatic logic glob_verdict();
    int ti, pi, back_ti, back_pi;
    bit starred;
    ti = 0;
    pi = 0;
    back_ti = 0;
    back_pi = 0;
    starred = 1'b0;
    while (ti < text_len) begin
      if (pi < pat_len && pat_chars[pi] == star_cur) begin
        pi++;
        starred = 1'b1;
        back_pi = pi;
        back_ti = ti;
      end else if (pi < pat_len &&
                   (pat_chars[pi] == any_cur || pat_chars[pi] == text_chars[ti])) begin
        pi++;
        ti++;
      end else if (starred) begin
        back_ti++;
        ti = back_ti;
        pi = back_pi;
      end else begin
        return 1'b0;
      end
    end
    while (pi < pat_len && pat_chars[pi] == star_cur) pi++;
    return (pi >= pat_len);
  endfunction

  // Apply one beat to the predicted state; a pattern terminator yields a verdict.
  function automatic void take_beat(logic kind, logic [7:0] chr);
    if (kind == KIND_TEXT) begin
      if (chr == 8'h00) begin
        text_done = 1'b1;
      end else if (!text_done && text_len < MAX_LEN - 1) begin
        text_chars[text_len] = chr;
        text_len++;
      end
    end else if (chr != 8'h00) begin
      if (pat_len < MAX_LEN - 1) begin
        pat_chars[pat_len] = chr;
        pat_len++;
      end
    end else begin
      verdict_q.push_back(glob_verdict());
      text_len = 0;
      pat_len = 0;
      text_done = 1'b0;
    end
  endfunction

  function automatic void push_beat(logic kind, logic [7:0] chr, logic drain);
    beat_t b;
    b.drain = drain;
    b.kind = kind;
    b.chr = chr;
    beat_q.push_back(b);
    beat_total++;
  endfunction

  // Mostly a small alphabet so that patterns hit, sometimes any nonzero byte.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(1, 255));
  endfunction

  // Queue one text/pattern pair; most patterns are derived from the text.
  function automatic void queue_pair(bit drain_first);
    logic [7:0] txt[$];
    logic [7:0] pat[$];
    int         mode, tlen, n, r;
    bit         drain;
    drain = drain_first || ($urandom_range(0, 9) == 0);
    mode = $urandom_range(0, 49);
    tlen = (mode == 0) ? $urandom_range(250, 300) : $urandom_range(0, 10);
    for (int i = 0; i < tlen; i++) txt.push_back(pick_char());
    if (mode != 0 && $urandom_range(0, 3) != 0) begin
      n = 0;
      while (n < txt.size()) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            pat.push_back(any_cur);
            n++;
          end
          3, 4: begin
            pat.push_back(star_cur);
            n += $urandom_range(0, 3);
          end
          5: pat.push_back(star_cur);
          6: begin
            pat.push_back(pick_char());
            n++;
          end
          7: n++;
          default: begin
            pat.push_back(txt[n]);
            n++;
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0) pat.push_back(star_cur);
    end else begin
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 19);
        pat.push_back(r < 5 ? star_cur : (r < 8 ? any_cur : pick_char()));
      end
    end
    // Overlong pattern, mostly stars, to hit truncation on the pattern side.
    if (mode == 1) begin
      repeat ($urandom_range(240, 280))
        pat.push_back(($urandom_range(0, 7) == 0) ? pick_char() : star_cur);
    end

    foreach (txt[i]) begin
      push_beat(KIND_TEXT, txt[i], drain);
      drain = 1'b0;
    end
    // Sometimes leave the text open, sometimes send a byte after its end.
    r = $urandom_range(0, 19);
    if (r >= 2) begin
      push_beat(KIND_TEXT, 8'h00, drain);
      drain = 1'b0;
      if (r == 2) push_beat(KIND_TEXT, pick_char(), 1'b0);
    end
    foreach (pat[i]) begin
      if ($urandom_range(0, 19) == 0) begin
        push_beat(KIND_TEXT, pick_char(), drain);
        drain = 1'b0;
      end
      push_beat(KIND_PATTERN, pat[i], drain);
      drain = 1'b0;
    end
    push_beat(KIND_PATTERN, 8'h00, drain);
  endfunction

  // Driver: every loaded beat is held until taken, so its prediction is made on load.
  beat_t nxt;
  bit    loaded = 1'b0;
  int    send_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= KIND_TEXT;
      in_char_byte <= 8'h00;
      loaded = 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        loaded = 1'b0;
        send_wait = send_pause();
      end
      if (!loaded) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (beat_q.size() != 0 && !(beat_q[0].drain && verdict_q.size() != 0)) begin
          nxt = beat_q.pop_front();
          take_beat(nxt.kind, nxt.chr);
          in_kind <= nxt.kind;
          in_char_byte <= nxt.chr;
          loaded = 1'b1;
        end
      end
      in_valid <= loaded;
    end
  end

  function automatic void check_verdict(logic got);
    logic want;
    if (verdict_q.size() == 0) begin
      note_error($sformatf("unexpected verdict beat: matched %0b", got));
      return;
    end
    want = verdict_q.pop_front();
    if (got !== want) note_error($sformatf("matched: expected %0b, got %0b", want, got));
  endfunction

  // Monitor: a stall is drawn per verdict and counted down while a verdict waits.
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_verdict(out_matched);
        hold_cnt = recv_pause();
      end else if (out_valid && hold_cnt > 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt > 0);
    end
  end

  task automatic cfg_access(logic idx, logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write a code register, mirror it in the prediction and read it back.
  task automatic set_code(logic idx, logic [7:0] val);
    logic [31:0] rd;
    cfg_access(idx, 1'b1, {24'($urandom), val}, rd);
    if (idx == REG_STAR) star_cur = val;
    else any_cur = val;
    cfg_access(idx, 1'b0, 32'h0, rd);
    if (rd[7:0] !== val)
      note_error($sformatf("register %0d readback: expected %02h, got %02h", idx, val, rd[7:0]));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (beat_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  initial begin
    int quota;
    int base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Byte extremes, star over a run.
    push_beat(KIND_TEXT, 8'hff, 1'b0);
    push_beat(KIND_TEXT, "a", 1'b0);
    push_beat(KIND_TEXT, 8'h00, 1'b0);
    push_beat(KIND_PATTERN, STAR_RESET, 1'b0);
    push_beat(KIND_PATTERN, 8'h00, 1'b0);
    // Empty text against an empty pattern.
    push_beat(KIND_TEXT, 8'h00, 1'b0);
    push_beat(KIND_PATTERN, 8'h00, 1'b0);
    // Empty text: a trailing any byte cannot match.
    push_beat(KIND_TEXT, 8'h00, 1'b0);
    push_beat(KIND_PATTERN, STAR_RESET, 1'b0);
    push_beat(KIND_PATTERN, ANY_RESET, 1'b0);
    push_beat(KIND_PATTERN, 8'h00, 1'b0);
    // Text byte after the text end is dropped.
    push_beat(KIND_TEXT, "a", 1'b0);
    push_beat(KIND_TEXT, 8'h00, 1'b0);
    push_beat(KIND_TEXT, "b", 1'b0);
    push_beat(KIND_PATTERN, "a", 1'b0);
    push_beat(KIND_PATTERN, 8'h00, 1'b0);
    // Open text keeps growing between pattern bytes.
    push_beat(KIND_TEXT, "x", 1'b0);
    push_beat(KIND_PATTERN, ANY_RESET, 1'b0);
    push_beat(KIND_TEXT, "y", 1'b0);
    push_beat(KIND_PATTERN, ANY_RESET, 1'b0);
    push_beat(KIND_PATTERN, 8'h00, 1'b0);
    // Pattern ends without a text end; a literal mismatch after a star.
    push_beat(KIND_TEXT, "c", 1'b0);
    push_beat(KIND_PATTERN, STAR_RESET, 1'b0);
    push_beat(KIND_PATTERN, "d", 1'b0);
    push_beat(KIND_PATTERN, 8'h00, 1'b0);

    // Random phases, each under its own pair of codes.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        wait_idle();
        repeat (20) @(posedge clk);
        case (ph)
          1: begin
            set_code(REG_STAR, 8'h01);
            set_code(REG_ANY, 8'hff);
          end
          2: begin
            set_code(REG_STAR, 8'hff);
            set_code(REG_ANY, 8'h01);
          end
          3: begin
            // Equal codes on a common letter: the star meaning wins.
            set_code(REG_STAR, "a");
            set_code(REG_ANY, "a");
          end
          default: begin
            set_code(REG_STAR, 8'($urandom_range(1, 255)));
            set_code(REG_ANY, 8'($urandom_range(1, 255)));
          end
        endcase
      end
      base = beat_total;
      quota = beat_total + 320;
      while (beat_total < quota) queue_pair(beat_total == base);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/wpm_pkg.sv
rtl/core/wpm_ram.sv
rtl/core/wpm_datapath.sv
rtl/core/wpm_ctrl.sv
rtl/core/wildcard_pattern_matcher.sv
tb/testbench.sv
